// File: rtl/row_major_flat_index_core_assert.svh
// assertion macros shared by the row-major flat index core modules
`ifndef ROW_MAJOR_FLAT_INDEX_CORE_ASSERT_SVH
`define ROW_MAJOR_FLAT_INDEX_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RMFI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmfi assertion failed");
// next-cycle implication
`define RMFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmfi assertion failed");
`else
`define RMFI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RMFI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/rmfi_pkg.sv
// shared types and constants for the row-major flat index core
package rmfi_pkg;

   localparam int MAX_DIMS   = 6;
   localparam int COORD_W    = 10;
   localparam int EXT_W      = 11;
   localparam int RANK_W     = 3;
   localparam int OFFSET_W   = 60;
   localparam int COUNT_W    = 61;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANK     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_0 = 3'd1;

   typedef struct packed {
      logic [RANK_W-1:0]  index_length;
      logic [COORD_W-1:0] coord_0;
      logic [COORD_W-1:0] coord_1;
      logic [COORD_W-1:0] coord_2;
      logic [COORD_W-1:0] coord_3;
      logic [COORD_W-1:0] coord_4;
      logic [COORD_W-1:0] coord_5;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] flat_offset;
      logic [ERR_W-1:0]    error_code;
      logic [COUNT_W-1:0]  element_count;
   } rsp_type;

endpackage

// File: rtl/rmfi_sweep.sv
// stride and element count unit, one dimension per cycle on a shared multiplier
`include "row_major_flat_index_core_assert.svh"

module rmfi_sweep #(
   parameter int MAX_RANK = 6,
   parameter int STRIDE_W = (MAX_RANK > 1) ? (MAX_RANK - 1) * rmfi_pkg::EXT_W : 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [rmfi_pkg::RANK_W-1:0]               rank,
   input  logic [MAX_RANK-1:0][rmfi_pkg::EXT_W-1:0]  extents,
   output logic                                      busy,
   output logic [MAX_RANK-1:0][STRIDE_W-1:0]         strides_ff,
   output logic [rmfi_pkg::COUNT_W-1:0]              count_ff
);

   localparam int RW     = rmfi_pkg::RANK_W;
   localparam int EW     = rmfi_pkg::EXT_W;
   localparam int PROD_W = MAX_RANK * EW;
   localparam logic [MAX_RANK-1:0] SEL_FIRST = MAX_RANK'(1) << (MAX_RANK - 1);

   logic [MAX_RANK-1:0] sel_ff;
   logic                fin_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [PROD_W-1:0]   acc_in;
   logic [EW-1:0]       ext_pick;
   logic                act_pick;

   // pick the extent of the dimension under work, outermost last
   always_comb begin
      ext_pick = '0;
      act_pick = 1'b0;
      for (int k = 0; k < MAX_RANK; k++) begin
         if (sel_ff[k]) begin
            ext_pick = ext_pick | extents[k];
            act_pick = act_pick | (rank > RW'(k));
         end
      end
      acc_in = acc_ff;
      if (act_pick) begin
         acc_in = acc_ff * ext_pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         sel_ff <= SEL_FIRST;
         fin_ff <= 1'b0;
         acc_ff <= PROD_W'(1);
      end else if (|sel_ff) begin
         sel_ff <= sel_ff >> 1;
         fin_ff <= sel_ff[0];
         acc_ff <= acc_in;
      end else begin
         fin_ff <= 1'b0;
      end
   end

   // stride of a dimension is the product of the used extents inside it
   always_ff @(posedge clock) begin
      if (|sel_ff) begin
         strides_ff[0] <= STRIDE_W'(acc_ff);
         for (int k = 1; k < MAX_RANK; k++) begin
            strides_ff[k] <= strides_ff[k-1];
         end
      end
      if (fin_ff) begin
         count_ff <= (acc_ff > PROD_W'(rmfi_pkg::COUNT_MAX)) ?
                     rmfi_pkg::COUNT_MAX : rmfi_pkg::COUNT_W'(acc_ff);
      end
   end

   assign busy = (|sel_ff) || fin_ff;

   `RMFI_ASSERT_IMPLY(a_sel_onehot, clock, reset, 1'b1, $onehot0(sel_ff))
   `RMFI_ASSERT_NEXT(a_sweep_ends, clock, reset, fin_ff && !start, !busy)

endmodule

// File: rtl/rmfi_lane.sv
// one coordinate lane: range check and coordinate times stride
module rmfi_lane #(
   parameter int COORD_BITS = 10,
   parameter int STRIDE_W   = 55
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic                           active,
   input  logic [COORD_BITS-1:0]          coord,
   input  logic [rmfi_pkg::EXT_W-1:0]     extent,
   input  logic [STRIDE_W-1:0]            stride,
   output logic [COORD_BITS+STRIDE_W-1:0] term_ff,
   output logic                           fault_ff
);

   localparam int TERM_W = COORD_BITS + STRIDE_W;
   localparam int EW     = rmfi_pkg::EXT_W;

   logic [TERM_W-1:0] term_in;
   logic              fault_in;

   // lanes beyond the rank add nothing and never fault
   always_comb begin
      term_in  = '0;
      if (active) begin
         term_in = coord * stride;
      end
      fault_in = active && (EW'(coord) >= extent);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         term_ff  <= term_in;
         fault_ff <= fault_in;
      end
   end

endmodule

// File: rtl/rmfi_merge.sv
// merge stage: pairwise sum of lane terms, final sum, saturation and error code
module rmfi_merge #(
   parameter int LANES  = 6,
   parameter int TERM_W = 65
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [LANES-1:0][TERM_W-1:0]       terms,
   input  logic [LANES-1:0]                   faults,
   input  logic                               rank_bad,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [rmfi_pkg::OFFSET_W-1:0]      out_offset,
   output logic [rmfi_pkg::ERR_W-1:0]         out_error
);

   localparam int PAIRS  = (LANES + 1) / 2;
   localparam int PAIR_W = TERM_W + 1;
   localparam int SUM_W  = PAIR_W + $clog2(PAIRS + 1);
   localparam int OW     = rmfi_pkg::OFFSET_W;

   logic                         vb_ff;
   logic                         vc_ff;
   logic                         ready_b;
   logic                         ready_c;
   logic [PAIRS-1:0][PAIR_W-1:0] pair_in;
   logic [PAIRS-1:0][PAIR_W-1:0] pair_ff;
   logic [rmfi_pkg::ERR_W-1:0]   err_b_in;
   logic [rmfi_pkg::ERR_W-1:0]   err_b_ff;
   logic [rmfi_pkg::ERR_W-1:0]   err_c_ff;
   logic [SUM_W-1:0]             sum_c;
   logic [OW-1:0]                off_c_in;
   logic [OW-1:0]                off_c_ff;

   for (genvar p = 0; p < PAIRS; p++) begin : g_pair
      if (2 * p + 1 < LANES) begin : g_two
         assign pair_in[p] = PAIR_W'(terms[2*p]) + PAIR_W'(terms[2*p+1]);
      end else begin : g_one
         assign pair_in[p] = PAIR_W'(terms[2*p]);
      end
   end

   // rank mismatch wins over a coordinate fault
   always_comb begin
      if (rank_bad) begin
         err_b_in = rmfi_pkg::ERR_RANK;
      end else if (|faults) begin
         err_b_in = rmfi_pkg::ERR_RANGE;
      end else begin
         err_b_in = rmfi_pkg::ERR_NONE;
      end
   end

   always_comb begin
      sum_c = '0;
      for (int p = 0; p < PAIRS; p++) begin
         sum_c = sum_c + SUM_W'(pair_ff[p]);
      end
      if (err_b_ff != rmfi_pkg::ERR_NONE) begin
         off_c_in = '0;
      end else if (sum_c > SUM_W'(rmfi_pkg::OFFSET_MAX)) begin
         off_c_in = rmfi_pkg::OFFSET_MAX;
      end else begin
         off_c_in = OW'(sum_c);
      end
   end

   assign ready_c  = !vc_ff || out_ready;
   assign ready_b  = !vb_ff || ready_c;
   assign in_ready = ready_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_b) begin
            vb_ff <= in_valid;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         pair_ff  <= pair_in;
         err_b_ff <= err_b_in;
      end
      if (ready_c) begin
         off_c_ff <= off_c_in;
         err_c_ff <= err_b_ff;
      end
   end

   assign out_valid  = vc_ff;
   assign out_offset = off_c_ff;
   assign out_error  = err_c_ff;

endmodule

// File: rtl/row_major_flat_index_core.sv
// top level of the row-major flat index core
`include "row_major_flat_index_core_assert.svh"

// Accepts one request per clock while req_ready is high and returns one response per
// request, in order, through the lane stage, pair-sum stage and output register. Each
// of the MAX_RANK lanes range-checks its coordinate and multiplies it by a precomputed
// stride; the merge stage adds the lane products, saturates at 2^60-1 and forms the
// error code. Strides and the element count come from one shared multiplier that walks
// the dimensions one per cycle: after reset and after every csr write, req_ready stays
// low while that walk runs. csr writes are always taken.
module row_major_flat_index_core #(
   parameter int MAX_RANK   = 6,
   parameter int COORD_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rmfi_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rmfi_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmfi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmfi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RW       = rmfi_pkg::RANK_W;
   localparam int EW       = rmfi_pkg::EXT_W;
   localparam int IW       = rmfi_pkg::CSR_IDX_W;
   localparam int STRIDE_W = (MAX_RANK > 1) ? (MAX_RANK - 1) * EW : 1;
   localparam int TERM_W   = COORD_BITS + STRIDE_W;

   logic [RW-1:0]                                 rank_ff;
   logic [MAX_RANK-1:0][EW-1:0]                   extent_ff;
   logic [rmfi_pkg::MAX_DIMS-1:0][rmfi_pkg::COORD_W-1:0] coord_all;
   logic [MAX_RANK-1:0][STRIDE_W-1:0]             strides;
   logic [rmfi_pkg::COUNT_W-1:0]                  count;
   logic                                          sweep_busy;
   logic                                          va_ff;
   logic                                          rank_bad_ff;
   logic                                          rank_bad_in;
   logic                                          ready_a;
   logic                                          merge_ready;
   logic [MAX_RANK-1:0][TERM_W-1:0]               terms;
   logic [MAX_RANK-1:0]                           faults;
   logic [rmfi_pkg::OFFSET_W-1:0]                 offset;
   logic [rmfi_pkg::ERR_W-1:0]                    error;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RW'(1);
         for (int k = 0; k < MAX_RANK; k++) begin
            extent_ff[k] <= EW'(1);
         end
      end else if (csr_valid) begin
         if (csr_index == rmfi_pkg::CSR_RANK) begin
            rank_ff <= csr_wdata[RW-1:0];
         end
         for (int k = 0; k < MAX_RANK; k++) begin
            if (csr_index == IW'(k) + rmfi_pkg::CSR_EXTENT_0) begin
               extent_ff[k] <= csr_wdata[EW-1:0];
            end
         end
      end
   end

   rmfi_sweep #(
      .MAX_RANK (MAX_RANK),
      .STRIDE_W (STRIDE_W)
   ) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_valid),
      .rank       (rank_ff),
      .extents    (extent_ff),
      .busy       (sweep_busy),
      .strides_ff (strides),
      .count_ff   (count)
   );

   assign coord_all[0] = req_data.coord_0;
   assign coord_all[1] = req_data.coord_1;
   assign coord_all[2] = req_data.coord_2;
   assign coord_all[3] = req_data.coord_3;
   assign coord_all[4] = req_data.coord_4;
   assign coord_all[5] = req_data.coord_5;

   assign ready_a     = !va_ff || merge_ready;
   assign req_ready   = !sweep_busy && ready_a;
   assign rank_bad_in = (rank_ff > RW'(MAX_RANK)) || (req_data.index_length != rank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (ready_a) begin
         va_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         rank_bad_ff <= rank_bad_in;
      end
   end

   for (genvar k = 0; k < MAX_RANK; k++) begin : g_lane
      rmfi_lane #(
         .COORD_BITS (COORD_BITS),
         .STRIDE_W   (STRIDE_W)
      ) u_lane (
         .clock    (clock),
         .enable   (ready_a),
         .active   (rank_ff > RW'(k)),
         .coord    (coord_all[k][COORD_BITS-1:0]),
         .extent   (extent_ff[k]),
         .stride   (strides[k]),
         .term_ff  (terms[k]),
         .fault_ff (faults[k])
      );
   end

   rmfi_merge #(
      .LANES  (MAX_RANK),
      .TERM_W (TERM_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (va_ff),
      .in_ready   (merge_ready),
      .terms      (terms),
      .faults     (faults),
      .rank_bad   (rank_bad_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_offset (offset),
      .out_error  (error)
   );

   always_comb begin
      rsp_data               = '0;
      rsp_data.flat_offset   = offset;
      rsp_data.error_code    = error;
      rsp_data.element_count = count;
   end

   `RMFI_ASSERT_NEXT(a_csr_holds_req, clock, reset, csr_valid && csr_ready, !req_ready)
   `RMFI_ASSERT_IMPLY(a_err_zero_offset, clock, reset, rsp_valid && (rsp_data.error_code != rmfi_pkg::ERR_NONE), rsp_data.flat_offset == '0)

endmodule
